@@ hw/rtl/tcw_pkg.sv @@
// ============================================================================
// Text console writer package
// Screen geometry, derived widths, character codes and the command and
// status records that pass between the controller and the datapath.
// ============================================================================
package tcw_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_LINES   = 24;
    localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_LINES;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int COL_W  = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W  = $clog2(SCREEN_LINES);
    localparam int CELL_W = 16;

    localparam logic [7:0] ATTR_RESET = 8'd7;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] PRINT_LOW  = 8'd32;
    localparam logic [7:0] PRINT_HIGH = 8'd126;

    typedef enum logic [1:0] {
        KIND_SERIAL = 2'd0,
        KIND_NONE   = 2'd1,
        KIND_CELL   = 2'd2
    } t_kind;

    // controller -> datapath
    typedef struct packed {
        logic load;         // latch the accepted item
        logic do_put;       // write cell, move cursor, start scroll clear
        logic clr_step;     // clear one cell of the sweep
        logic post;         // load the output register
        logic post_second;  // second echo result of LF
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_read;      // item on the input is a cell read
        logic is_lf;        // latched character is LF
        logic scroll;       // this put moves past the last line
        logic clr_last;     // sweep is at its final cell
        logic out_free;     // output register can take a result
    } t_stat;

endpackage

@@ hw/rtl/tcw_ram.sv @@
// ============================================================================
// Generic RAM
// One write port, one read port with registered read data.
// ============================================================================
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1920
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/tcw_ctrl.sv @@
// ============================================================================
// Text console writer controller
// Sequences reset clear, cell reads, puts, scroll clears and echo results.
// ============================================================================
module tcw_ctrl import tcw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_PUT,
        S_SCROLL,
        S_EMIT1,
        S_EMIT2
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;
    t_cmd   cmd;
    logic   accept;

    assign accept = i_in_valid && r_ready;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    n_state  = i_stat.in_read ? S_READ : S_PUT;
                end
            end
            S_READ: begin
                if (i_stat.out_free) begin
                    cmd.post = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_PUT: begin
                cmd.do_put = 1'b1;
                if (i_stat.scroll) begin
                    n_state = S_SCROLL;
                end else if (i_stat.out_free) begin
                    cmd.post = 1'b1;
                    n_state  = i_stat.is_lf ? S_EMIT2 : S_IDLE;
                end else begin
                    n_state = S_EMIT1;
                end
            end
            S_SCROLL: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_EMIT1;
                end
            end
            S_EMIT1: begin
                if (i_stat.out_free) begin
                    cmd.post = 1'b1;
                    n_state  = i_stat.is_lf ? S_EMIT2 : S_IDLE;
                end
            end
            S_EMIT2: begin
                if (i_stat.out_free) begin
                    cmd.post        = 1'b1;
                    cmd.post_second = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_ready;
    assign o_cmd      = cmd;

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !r_ready)
        else $error("tcw_ctrl: input taken twice in a row");

    // only LF produces a second result
    a_second_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT2) |-> i_stat.is_lf)
        else $error("tcw_ctrl: second result for non-LF");

endmodule

@@ hw/rtl/tcw_dp.sv @@
// ============================================================================
// Text console writer datapath
// Screen RAM with rotating top row, cursor, clear sweep and output register.
// ============================================================================
module tcw_dp import tcw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_op,
    input  logic [7:0]  i_in_char,
    input  logic [4:0]  i_in_row,
    input  logic [6:0]  i_in_col,
    input  logic        i_out_ready,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_out_valid,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_out_serial,
    output logic [7:0]  o_out_cell_char,
    output logic [7:0]  o_out_cell_attr,
    output logic [6:0]  o_out_col,
    output logic [4:0]  o_out_row,
    output logic        o_out_last
);

    // logical row plus top pointer, folded once, times the row pitch
    function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] top,
                                                    logic [6:0] row,
                                                    logic [7:0] col);
        logic [7:0]       sum;
        logic [ROW_W-1:0] phys;
        sum = 8'(top) + 8'(row);
        if (sum >= 8'(SCREEN_LINES)) begin
            sum = sum - 8'(SCREEN_LINES);
        end
        phys = ROW_W'(sum);
        return ADDR_W'(32'(phys) * SCREEN_COLUMNS + 32'(col));
    endfunction

    logic [7:0]        r_attr;
    logic              r_op;
    logic [7:0]        r_char;
    logic [ADDR_W-1:0] r_rd_addr;
    logic              r_rd_ok;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [ROW_W-1:0]  r_top, n_top;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] r_clr_cnt;

    logic              r_out_valid;
    logic [1:0]        r_out_kind;
    logic [7:0]        r_out_serial;
    logic [7:0]        r_out_cell_char;
    logic [7:0]        r_out_cell_attr;
    logic [6:0]        r_out_col;
    logic [4:0]        r_out_row;
    logic              r_out_last;

    logic [ADDR_W-1:0] in_addr, cur_addr, ram_raddr, ram_waddr;
    logic [CELL_W-1:0] ram_rdata, ram_wdata;
    logic              ram_we;
    logic              in_ok;
    logic              is_cr, is_lf, is_nl, is_print;
    logic              at_eol, at_bottom, wrap, scroll, out_free;

    assign in_addr  = cell_addr(r_top, 7'(i_in_row), 8'(i_in_col));
    assign cur_addr = cell_addr(r_top, 7'(r_row), 8'(r_col));
    assign in_ok    = (32'(i_in_row) < SCREEN_LINES) && (32'(i_in_col) < SCREEN_COLUMNS);

    assign is_cr     = (r_char == CH_CR);
    assign is_lf     = (r_char == CH_LF);
    assign is_nl     = is_cr || is_lf;
    assign is_print  = (r_char >= PRINT_LOW) && (r_char <= PRINT_HIGH);
    assign at_eol    = (r_col == COL_W'(SCREEN_COLUMNS - 1));
    assign at_bottom = (r_row == ROW_W'(SCREEN_LINES - 1));
    assign wrap      = is_nl || at_eol;
    assign scroll    = wrap && at_bottom;
    assign out_free  = !r_out_valid || i_out_ready;

    // cursor after the put
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_top = r_top;
        if (i_cmd.do_put) begin
            if (wrap) begin
                n_col = '0;
                if (at_bottom) begin
                    n_top = (r_top == ROW_W'(SCREEN_LINES - 1)) ? '0 : r_top + 1'b1;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // clear sweep has the write port to itself
    assign ram_we    = i_cmd.clr_step || (i_cmd.do_put && !is_nl);
    assign ram_waddr = i_cmd.clr_step ? r_clr_addr : cur_addr;
    assign ram_wdata = i_cmd.clr_step ? '0 : {r_attr, r_char};
    assign ram_raddr = i_cmd.load ? in_addr : r_rd_addr;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr     <= ATTR_RESET;
            r_col      <= '0;
            r_row      <= '0;
            r_top      <= '0;
            r_clr_addr <= '0;
            r_clr_cnt  <= ADDR_W'(CELL_COUNT - 1);
        end else begin
            if (i_cfg_wen) begin
                r_attr <= i_cfg_wdata;
            end
            r_col <= n_col;
            r_row <= n_row;
            r_top <= n_top;
            if (i_cmd.do_put && scroll) begin
                // old top row becomes the new bottom row
                r_clr_addr <= ADDR_W'(32'(r_top) * SCREEN_COLUMNS);
                r_clr_cnt  <= ADDR_W'(SCREEN_COLUMNS - 1);
            end else if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                r_clr_cnt  <= r_clr_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_in_op;
            r_char    <= i_in_char;
            r_rd_addr <= in_addr;
            r_rd_ok   <= in_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.post) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            r_out_col       <= 7'(n_col);
            r_out_row       <= 5'(n_row);
            r_out_cell_char <= '0;
            r_out_cell_attr <= '0;
            r_out_serial    <= '0;
            r_out_last      <= 1'b1;
            if (r_op) begin
                r_out_kind <= KIND_CELL;
                if (r_rd_ok) begin
                    r_out_cell_char <= ram_rdata[7:0];
                    r_out_cell_attr <= ram_rdata[15:8];
                end
            end else if (i_cmd.post_second) begin
                r_out_kind   <= KIND_SERIAL;
                r_out_serial <= CH_LF;
            end else if (is_lf) begin
                r_out_kind   <= KIND_SERIAL;
                r_out_serial <= CH_CR;
                r_out_last   <= 1'b0;
            end else if (is_cr || is_print) begin
                r_out_kind   <= KIND_SERIAL;
                r_out_serial <= r_char;
            end else begin
                r_out_kind <= KIND_NONE;
            end
        end
    end

    assign o_stat.in_read  = i_in_op;
    assign o_stat.is_lf    = is_lf;
    assign o_stat.scroll   = scroll;
    assign o_stat.clr_last = (r_clr_cnt == '0);
    assign o_stat.out_free = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_out_kind      = r_out_kind;
    assign o_out_serial    = r_out_serial;
    assign o_out_cell_char = r_out_cell_char;
    assign o_out_cell_attr = r_out_cell_attr;
    assign o_out_col       = r_out_col;
    assign o_out_row       = r_out_row;
    assign o_out_last      = r_out_last;

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_col) < SCREEN_COLUMNS) && (32'(r_row) < SCREEN_LINES) &&
        (32'(r_top) < SCREEN_LINES))
        else $error("tcw_dp: cursor or top row out of range");

    a_post_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.post |-> out_free)
        else $error("tcw_dp: result posted over a pending one");

    a_scroll_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.do_put && scroll) |=>
        (r_clr_cnt == ADDR_W'(SCREEN_COLUMNS - 1)) && (r_col == '0) &&
        (r_row == ROW_W'(SCREEN_LINES - 1)))
        else $error("tcw_dp: scroll did not set up row clear");

endmodule

@@ hw/rtl/text_console_writer_unit.sv @@
// ============================================================================
// Text console writer unit
// Character console with 24x80 screen, cursor, scroll and serial echo.
// ============================================================================
// Usage:
//   Items enter on the s_axis channel. tuser selects the operation: a put
//   writes tdata's character with the current attribute at the cursor and
//   advances it (CR/LF and end of line start a new line); a read returns one
//   cell. Results leave on m_axis; tlast marks the last result of an item.
//   LF echoes CR then LF, so it gives two results; every other item gives one.
//   The user must write the attribute register (i_cfg_wen/i_cfg_wdata)
//   only while idle; the unit itself does not enforce this.
// Operation:
//   A read or a non-scrolling put is accepted in S_IDLE, does its registered
//   RAM read or cell RAM write in S_READ or S_PUT and is posted once the
//   output register is free; only then is a new item taken. LF posts its
//   second result from S_EMIT2. A put that scrolls rotates the rows through a
//   top-row pointer, clears the recycled row one cell per cycle, then posts.
// Reset:
//   Cursor goes home, attribute becomes 7, and a clearing pass writes zero to
//   all 1920 cells, one per cycle; s_axis_tready stays low during that pass.
// Stalls:
//   A result sits in the output register until m_axis_tready; the unit may
//   accept the next item meanwhile and waits only when it must post again.
// ============================================================================
module text_console_writer_unit import tcw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] char_code, [12:8] read_row, [19:13] read_col, [23:20] zero
    input  logic [23:0] s_axis_tdata,
    // [0] operation
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] serial_byte, [15:8] cell_char, [23:16] cell_attr,
    // [30:24] cursor_col, [35:31] cursor_row, [39:36] zero
    output logic [39:0] m_axis_tdata,
    // [1:0] kind
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    t_cmd       cmd;
    t_stat      stat;
    logic [7:0] out_serial, out_cell_char, out_cell_attr;
    logic [6:0] out_col;
    logic [4:0] out_row;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tcw_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_op         (s_axis_tuser[0]),
        .i_in_char       (s_axis_tdata[7:0]),
        .i_in_row        (s_axis_tdata[12:8]),
        .i_in_col        (s_axis_tdata[19:13]),
        .i_out_ready     (m_axis_tready),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_out_valid     (m_axis_tvalid),
        .o_out_kind      (m_axis_tuser),
        .o_out_serial    (out_serial),
        .o_out_cell_char (out_cell_char),
        .o_out_cell_attr (out_cell_attr),
        .o_out_col       (out_col),
        .o_out_row       (out_row),
        .o_out_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, out_row, out_col, out_cell_attr, out_cell_char,
                           out_serial};

endmodule

@@ sim/tb_top.sv @@
// ============================================================================
// Text console writer unit testbench
// Streams put and read items into the console, keeps its own screen, cursor
// and attribute copy, and checks every result item on m_axis field by field
// under several sender and receiver idling mixes and attribute settings.
// ============================================================================
module tb_top;
    import tcw_pkg::*;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // quiet cycles allowed before the run is declared hung; the clearing pass
    // after reset over all 1920 cells has no handshake at all
    localparam int STALL_LIMIT   = 8000;
    // wait after the results drain, before an attribute write or the end of run
    localparam int SETTLE_CYCLES = 100;

    // one result item as it appears on m_axis
    typedef struct packed {
        t_kind             kind;
        logic [7:0]        serial_byte;
        logic [7:0]        cell_char;
        logic [7:0]        cell_attr;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              last;
    } t_console_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wen = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [7:0] char_code, [12:8] read_row, [19:13] read_col, [23:20] zero
    logic [23:0] s_axis_tdata = 24'd0;
    // [0] operation
    logic [0:0]  s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] serial_byte, [15:8] cell_char, [23:16] cell_attr,
    // [30:24] cursor_col, [35:31] cursor_row, [39:36] zero
    logic [39:0] m_axis_tdata;
    // [1:0] kind
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // console shadow: screen cells, cursor and attribute as the unit keeps them
    logic [15:0]       screen_model [SCREEN_LINES][SCREEN_COLUMNS];
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [7:0]        attr_model;

    t_console_result   pending_results[$];
    int                mismatch_count = 0;
    int                quiet_cycles = 0;

    // idling mix in percent, changed per phase
    int                send_idle_pct = 0;
    int                sink_stall_pct = 0;

    text_console_writer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shadow console
    // ------------------------------------------------------------------------
    initial begin
        for (int r = 0; r < SCREEN_LINES; r++)
            for (int c = 0; c < SCREEN_COLUMNS; c++)
                screen_model[r][c] = 16'd0;
        cur_col    = '0;
        cur_row    = '0;
        attr_model = ATTR_RESET;
    end

    // new line; below the last line the rows move up and the bottom is blanked
    task automatic advance_line();
        cur_col = '0;
        if (cur_row == SCREEN_LINES - 1) begin
            for (int r = 0; r < SCREEN_LINES - 1; r++)
                for (int c = 0; c < SCREEN_COLUMNS; c++)
                    screen_model[r][c] = screen_model[r + 1][c];
            for (int c = 0; c < SCREEN_COLUMNS; c++)
                screen_model[SCREEN_LINES - 1][c] = 16'd0;
        end else begin
            cur_row++;
        end
    endtask

    // apply one accepted item to the shadow and queue the results it causes
    task automatic console_predict(input logic op, input logic [7:0] ch,
                                   input logic [4:0] row, input logic [6:0] col);
        t_console_result res;
        t_console_result cr_echo;
        logic [15:0]     cell_word;
        res       = '0;
        cell_word = 16'd0;
        if (op == OP_READ) begin
            // off-screen coordinates read as a blank cell
            if (row < SCREEN_LINES && col < SCREEN_COLUMNS)
                cell_word = screen_model[row][col];
            res.kind       = KIND_CELL;
            res.cell_char  = cell_word[7:0];
            res.cell_attr  = cell_word[15:8];
            res.cursor_col = cur_col;
            res.cursor_row = cur_row;
            res.last       = 1'b1;
            pending_results.push_back(res);
            return;
        end
        if (ch == CH_CR || ch == CH_LF) begin
            advance_line();
        end else begin
            screen_model[cur_row][cur_col] = {attr_model, ch};
            cur_col++;
            if (cur_col >= SCREEN_COLUMNS)
                advance_line();
        end
        res.cursor_col = cur_col;
        res.cursor_row = cur_row;
        res.last       = 1'b1;
        if (ch == CH_LF) begin
            // LF echoes as CR then LF
            cr_echo             = res;
            cr_echo.kind        = KIND_SERIAL;
            cr_echo.serial_byte = CH_CR;
            cr_echo.last        = 1'b0;
            pending_results.push_back(cr_echo);
            res.kind        = KIND_SERIAL;
            res.serial_byte = CH_LF;
        end else if (ch == CH_CR || (ch >= PRINT_LOW && ch <= PRINT_HIGH)) begin
            res.kind        = KIND_SERIAL;
            res.serial_byte = ch;
        end else begin
            res.kind = KIND_NONE;
        end
        pending_results.push_back(res);
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // tvalid is left high on return so back-to-back items need no gap;
    // stop_sending drops it once a sequence is over
    task automatic send_console_item(input logic op, input logic [7:0] ch,
                                     input logic [4:0] row, input logic [6:0] col);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, col, row, ch};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        console_predict(op, ch, row, col);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_put(input logic [7:0] ch);
        send_console_item(OP_PUT, ch, 5'($urandom), 7'($urandom));
    endtask

    task automatic send_read(input logic [4:0] row, input logic [6:0] col);
        send_console_item(OP_READ, 8'($urandom), row, col);
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // attribute changes only with the unit idle and any scroll sweep finished
    task automatic write_attribute(input logic [7:0] value);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        attr_model   = value;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    // mostly text with line breaks and reads of live cells; the rest is
    // arbitrary bytes and reads anywhere in the coordinate fields
    task automatic send_random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            send_put(8'($urandom_range(PRINT_HIGH, PRINT_LOW)));
        else if (pick < 63)
            send_put(CH_LF);
        else if (pick < 68)
            send_put(CH_CR);
        else if (pick < 78)
            send_read(5'($urandom_range(SCREEN_LINES - 1)),
                      7'($urandom_range(SCREEN_COLUMNS - 1)));
        else if (pick < 86)
            send_read(5'($urandom), 7'($urandom));
        else
            send_put(8'($urandom));
    endtask

    task automatic run_traffic_phase(input int idle_pct, input int stall_pct,
                                     input int item_count);
        int sent;
        int run;
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        sent = 0;
        while (sent < item_count) begin
            if ($urandom_range(99) < 8) begin
                // long text run: wraps when it reaches the end of the line and, near the bottom, scrolls
                run = $urandom_range(90, 70);
                if (run > item_count - sent)
                    run = item_count - sent;
                repeat (run) send_put(8'($urandom_range(PRINT_HIGH, PRINT_LOW)));
                sent += run;
            end else begin
                send_random_item();
                sent++;
            end
        end
        stop_sending();
    endtask

    // ------------------------------------------------------------------------
    // Output side: receiver stalls and result check
    // ------------------------------------------------------------------------
    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("ERROR: %s", msg);
    endtask

    always @(posedge i_clk) begin
        t_console_result got;
        t_console_result want;
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind        = t_kind'(m_axis_tuser);
            got.serial_byte = m_axis_tdata[7:0];
            got.cell_char   = m_axis_tdata[15:8];
            got.cell_attr   = m_axis_tdata[23:16];
            got.cursor_col  = m_axis_tdata[30:24];
            got.cursor_row  = m_axis_tdata[35:31];
            got.last        = m_axis_tlast;
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected item kind=%0d byte=%0d",
                                       got.kind, got.serial_byte));
            end else begin
                want = pending_results.pop_front();
                if (got !== want)
                    note_failure($sformatf({"kind %0d/%0d byte %0d/%0d ",
                        "cell %0d/%0d attr %0d/%0d col %0d/%0d row %0d/%0d ",
                        "last %0d/%0d (expected/actual)"},
                        want.kind, got.kind, want.serial_byte, got.serial_byte,
                        want.cell_char, got.cell_char, want.cell_attr, got.cell_attr,
                        want.cursor_col, got.cursor_col, want.cursor_row,
                        got.cursor_row, want.last, got.last));
            end
        end
    end

    // hang detector: counts cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("text_console_writer_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // blank screen reads, the byte classes of the echo, CR and LF, reads
    // off the screen edge and read-back of what was just written
    task automatic test_directed();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        send_read(5'd0, 7'd0);
        send_read(5'd23, 7'd79);
        send_read(5'd31, 7'd127);
        send_read(5'd24, 7'd0);
        send_read(5'd0, 7'd80);
        send_put(8'd65);
        send_put(PRINT_LOW);
        send_put(PRINT_HIGH);
        send_put(PRINT_LOW - 8'd1);
        send_put(PRINT_HIGH + 8'd1);
        send_put(8'd0);
        send_put(8'd255);
        send_put(8'd9);
        send_read(5'd0, 7'd0);
        send_read(5'd0, 7'd6);
        send_read(5'd0, 7'd8);
        send_put(CH_CR);
        send_put(8'd66);
        send_put(CH_LF);
        send_put(CH_LF);
        send_read(5'd1, 7'd0);
        send_read(5'd3, 7'd0);
        stop_sending();
    endtask

    // attribute at both ends of its range, each checked by read-back
    task automatic test_attribute_extremes();
        logic [4:0] row;
        logic [6:0] col;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        write_attribute(8'h00);
        repeat (6) begin
            row = cur_row;
            col = cur_col;
            send_put(8'($urandom));
            send_read(row, col);
        end
        stop_sending();
        write_attribute(8'hFF);
        repeat (6) begin
            row = cur_row;
            col = cur_col;
            send_put(8'($urandom));
            send_read(row, col);
        end
        stop_sending();
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(0, 0, 160);
        write_attribute(8'($urandom));
        run_traffic_phase(79, 0, 160);
        write_attribute(8'h00);
        run_traffic_phase(0, 79, 160);
        write_attribute(8'($urandom));
        run_traffic_phase(38, 38, 160);
    endtask

    // sender holds off mid-stream until every outstanding result is out
    task automatic test_sender_pause();
        write_attribute(8'hFF);
        run_traffic_phase(0, 38, 30);
        wait_results_drained();
        run_traffic_phase(38, 0, 30);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_attribute_extremes();
        test_random_traffic();
        test_sender_pause();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("text_console_writer_unit verification clean");
        else
            $display("text_console_writer_unit verification failed");
        $finish;
    end

endmodule
